[rtl/core/cgmi_pkg.sv]
// Shared types, constants and the radix-2 divider step for the grid indexer.
// No dependencies.
package cgmi_pkg;

	localparam int CNT_W     = 8;            // cell count register width
	localparam int MAX_CELLS = 255;
	localparam int SP_W      = 32;           // spacing register width
	localparam int IDX_W     = 27;           // request index width
	localparam int VAL_W     = 40;           // result value width
	localparam int SLOT_W    = 4;
	localparam int NSLOT     = 12;
	localparam int CFG_A_W   = 3;
	localparam int A_W       = 24;           // dividend width after range check
	localparam int D_W       = 9;            // divisor / remainder width
	localparam int STEPS     = 4;            // quotient bits per divider stage
	localparam int DIV_ST    = A_W / STEPS;  // stages per division
	localparam int NDIV      = 2 * DIV_ST;
	localparam int P1_W      = 2 * D_W;      // first-level products
	localparam int N_W       = P1_W + D_W;   // element counts

	typedef enum logic [1:0] {
		OP_VERTEX = 2'd0,
		OP_FACE   = 2'd1,
		OP_CELL   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		K_VERT,
		K_FACE,
		K_CELL,
		K_ERR
	} kind_t;

	typedef enum logic [1:0] {
		R_YZ,
		R_XZ,
		R_XY
	} region_t;

	typedef enum logic [CFG_A_W-1:0] {
		REG_CX = 3'd0,
		REG_CY = 3'd1,
		REG_CZ = 3'd2,
		REG_SX = 3'd3,
		REG_SY = 3'd4,
		REG_SZ = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [A_W-1:0] work;   // dividend shifting out, quotient shifting in
		logic [D_W-1:0] rem;
	} div_t;

	typedef struct packed {
		logic           v;
		kind_t          kind;
		region_t        region;
		logic           s;
		logic [A_W-1:0] cidx;
		logic [D_W-1:0] d1;
		logic [D_W-1:0] d2;
		logic [D_W-1:0] r1;
		div_t           dv;
	} pipe_t;

	function automatic div_t div_step(input div_t a, input logic [D_W-1:0] d);
		div_t         r;
		logic [D_W:0] t;
		r = a;
		for (int i = 0; i < STEPS; i++) begin
			t = {r.rem, r.work[A_W-1]};
			if (t >= {1'b0, d}) begin
				r.rem  = D_W'(t - {1'b0, d});
				r.work = {r.work[A_W-2:0], 1'b1};
			end else begin
				r.rem  = t[D_W-1:0];
				r.work = {r.work[A_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

[rtl/core/cuboid_grid_mesh_indexer.sv]
// Structured hexahedral grid indexer: vertex coordinates, face corners, cell faces.
// Depends on cgmi_pkg.
//
// Requests enter a 16-stage pipeline (input, decode, range check, two 6-stage
// pipelined dividers that split the index into x/y/z, a multiply stage) and
// land in an output buffer that plays the answer out one result per cycle
// while m_tready is high. A vertex or face request yields 3 results, a cell
// 12, a bad index or code one result with error set. The buffer holds one
// answer at a time and frees in the same cycle that its last result is taken.
// When the buffer is still busy the whole pipeline holds.
module cuboid_grid_mesh_indexer import cgmi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // [26:0] item_index
	input  logic [1:0]         s_tuser,   // [1:0] operation
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [47:0]        m_tdata,   // [3:0] slot, [43:4] value, [44] error
	output logic               m_tlast,
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [SP_W-1:0]    cfg_wdata
);

	// configuration
	logic [CNT_W-1:0] cx_q, cy_q, cz_q;
	logic [SP_W-1:0]  sx_q, sy_q, sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= CNT_W'(1);
			cy_q <= CNT_W'(1);
			cz_q <= CNT_W'(1);
			sx_q <= SP_W'(65536);
			sy_q <= SP_W'(65536);
			sz_q <= SP_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CX:  cx_q <= cfg_wdata[CNT_W-1:0];
				REG_CY:  cy_q <= cfg_wdata[CNT_W-1:0];
				REG_CZ:  cz_q <= cfg_wdata[CNT_W-1:0];
				REG_SX:  sx_q <= cfg_wdata;
				REG_SY:  sy_q <= cfg_wdata;
				REG_SZ:  sz_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	function automatic logic [D_W-1:0] eff(input logic [CNT_W-1:0] c);
		logic [D_W-1:0] r;
		if (c == '0)
			r = D_W'(1);
		else if (D_W'(c) > D_W'(MAX_CELLS))
			r = D_W'(MAX_CELLS);
		else
			r = D_W'(c);
		return r;
	endfunction

	// derived grid constants, registered from the config; element counts sit two register levels behind it
	logic [D_W-1:0]  w_q, t_q, h_q, row_q, t1_q, h1_q;
	logic [P1_W-1:0] th_q, wh_q, wt_q, layer_q, rowt_q, wt1_q;
	logic [N_W-1:0]  nyz_q, nv_q, ncell_q, nyzxz_q, nall_q;
	logic [D_W-1:0]  we_c, te_c, he_c;

	always_comb begin
		we_c = eff(cx_q);
		te_c = eff(cy_q);
		he_c = eff(cz_q);
	end

	always_ff @(posedge clk) begin
		w_q     <= we_c;
		t_q     <= te_c;
		h_q     <= he_c;
		row_q   <= we_c + 1'b1;
		t1_q    <= te_c + 1'b1;
		h1_q    <= he_c + 1'b1;
		th_q    <= P1_W'(te_c) * P1_W'(he_c);
		wh_q    <= P1_W'(we_c) * P1_W'(he_c);
		wt_q    <= P1_W'(we_c) * P1_W'(te_c);
		layer_q <= P1_W'(we_c + 1'b1) * P1_W'(te_c + 1'b1);
		rowt_q  <= P1_W'(we_c + 1'b1) * P1_W'(te_c);
		wt1_q   <= P1_W'(we_c) * P1_W'(te_c + 1'b1);
		nyz_q   <= N_W'(th_q) * N_W'(row_q);
		nv_q    <= N_W'(layer_q) * N_W'(h1_q);
		ncell_q <= N_W'(wt_q) * N_W'(h_q);
		nyzxz_q <= N_W'(th_q) * N_W'(row_q) + N_W'(wh_q) * N_W'(t1_q);
		nall_q  <= N_W'(th_q) * N_W'(row_q) + N_W'(wh_q) * N_W'(t1_q)
			+ N_W'(wt_q) * N_W'(h1_q);
	end

	// output buffer handshake drives the global stall
	logic            ob_busy_q;
	logic [SLOT_W-1:0] ob_cnt_q, ob_lst_q;
	logic            ob_err_q;
	logic [VAL_W-1:0] ob_val_q [NSLOT];
	logic            take, fin, en;

	assign take     = m_tvalid & m_tready;
	assign fin      = take && (ob_cnt_q == ob_lst_q);
	assign en       = !ob_busy_q || fin;
	assign s_tready = en;

	// s1: capture, s2: decode, s3: range check
	logic             v_s1, v_s2, v_s3;
	logic [1:0]       op_s1, op_s2, op_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic [IDX_W-2:0] p_s2, p_s3;
	logic             s_s2, s_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= s_tuser;
			idx_s1 <= s_tdata[IDX_W-1:0];
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			p_s2   <= idx_s1[IDX_W-1:1];
			s_s2   <= idx_s1[0];
			op_s3  <= op_s2;
			idx_s3 <= idx_s2;
			p_s3   <= p_s2;
			s_s3   <= s_s2;
		end
	end

	pipe_t          chk;
	logic           ok_v, ok_c, ok_f, in_yz, in_xz;
	logic [N_W-1:0] pm1, pm2;

	always_comb begin
		ok_v  = N_W'(idx_s3) < nv_q;
		ok_c  = N_W'(idx_s3) < ncell_q;
		ok_f  = N_W'(p_s3) < nall_q;
		in_yz = N_W'(p_s3) < nyz_q;
		in_xz = N_W'(p_s3) < nyzxz_q;
		pm1   = N_W'(p_s3) - nyz_q;
		pm2   = N_W'(p_s3) - nyzxz_q;
		chk         = '0;
		chk.v       = v_s3;
		chk.s       = s_s3;
		chk.cidx    = idx_s3[A_W-1:0];
		chk.kind    = K_ERR;
		chk.region  = R_YZ;
		chk.d1      = D_W'(1);
		chk.d2      = D_W'(1);
		priority if (op_s3 == OP_VERTEX && ok_v) begin
			chk.kind    = K_VERT;
			chk.dv.work = idx_s3[A_W-1:0];
			chk.d1      = row_q;
			chk.d2      = t1_q;
		end else if (op_s3 == OP_FACE && ok_f) begin
			chk.kind = K_FACE;
			if (in_yz) begin
				chk.region  = R_YZ;
				chk.dv.work = p_s3[A_W-1:0];
				chk.d1      = row_q;
				chk.d2      = t_q;
			end else if (in_xz) begin
				chk.region  = R_XZ;
				chk.dv.work = pm1[A_W-1:0];
				chk.d1      = w_q;
				chk.d2      = t1_q;
			end else begin
				chk.region  = R_XY;
				chk.dv.work = pm2[A_W-1:0];
				chk.d1      = w_q;
				chk.d2      = t_q;
			end
		end else if (op_s3 == OP_CELL && ok_c) begin
			chk.kind    = K_CELL;
			chk.dv.work = idx_s3[A_W-1:0];
			chk.d1      = w_q;
			chk.d2      = t_q;
		end else begin
			chk.kind = K_ERR;
		end
	end

	// two chained pipelined dividers: idx -> (q1, x), q1 -> (z, y)
	pipe_t dv_s [NDIV];
	pipe_t dv_nx [NDIV];

	always_comb begin
		pipe_t src;
		for (int k = 0; k < NDIV; k++) begin
			src = (k == 0) ? chk : dv_s[k-1];
			if (k == DIV_ST) begin
				src.r1     = src.dv.rem;
				src.dv.rem = '0;
			end
			dv_nx[k]    = src;
			dv_nx[k].dv = div_step(src.dv, (k < DIV_ST) ? src.d1 : src.d2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NDIV; k++)
				dv_s[k] <= '0;
		end else if (en) begin
			for (int k = 0; k < NDIV; k++)
				dv_s[k] <= dv_nx[k];
		end
	end

	// s16: products
	pipe_t            fin_p;
	logic [D_W-1:0]   px, py, pz;
	logic             v_s16, s_s16;
	kind_t            kind_s16;
	region_t          region_s16;
	logic [A_W-1:0]   cidx_s16;
	logic [D_W-1:0]   x_s16;
	logic [P1_W-1:0]  ry_s16, wy_s16;
	logic [N_W-1:0]   lz_s16, rtz_s16, wt1z_s16;
	logic [VAL_W:0]   cxp_s16, cyp_s16, czp_s16;

	assign fin_p = dv_s[NDIV-1];
	assign px    = fin_p.r1;
	assign py    = fin_p.dv.rem;
	assign pz    = fin_p.dv.work[D_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s16 <= 1'b0;
		else if (en)
			v_s16 <= fin_p.v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s16   <= fin_p.kind;
			region_s16 <= fin_p.region;
			s_s16      <= fin_p.s;
			cidx_s16   <= fin_p.cidx;
			x_s16      <= px;
			ry_s16     <= P1_W'(row_q) * P1_W'(py);
			wy_s16     <= P1_W'(w_q) * P1_W'(py);
			lz_s16     <= N_W'(layer_q) * N_W'(pz);
			rtz_s16    <= N_W'(rowt_q) * N_W'(pz);
			wt1z_s16   <= N_W'(wt1_q) * N_W'(pz);
			cxp_s16    <= (VAL_W+1)'(sx_q) * (VAL_W+1)'(px);
			cyp_s16    <= (VAL_W+1)'(sy_q) * (VAL_W+1)'(py);
			czp_s16    <= (VAL_W+1)'(sz_q) * (VAL_W+1)'(pz);
		end
	end

	function automatic logic [VAL_W-1:0] sat(input logic [VAL_W:0] p);
		return p[VAL_W] ? {VAL_W{1'b1}} : p[VAL_W-1:0];
	endfunction

	// result assembly
	logic [VAL_W-1:0]  vals [NSLOT];
	logic [SLOT_W-1:0] nlst;
	logic              nerr;
	logic [VAL_W-1:0]  v0, lay, row, one, f0, f4, f8;

	always_comb begin
		lay = VAL_W'(layer_q);
		row = VAL_W'(row_q);
		one = VAL_W'(1);
		v0  = VAL_W'(x_s16) + VAL_W'(ry_s16) + VAL_W'(lz_s16);
		f0  = (VAL_W'(x_s16) + VAL_W'(ry_s16) + VAL_W'(rtz_s16)) << 1;
		f4  = (VAL_W'(nyz_q) + VAL_W'(x_s16) + VAL_W'(wy_s16) + VAL_W'(wt1z_s16)) << 1;
		f8  = (VAL_W'(nyzxz_q) + VAL_W'(cidx_s16)) << 1;
		for (int k = 0; k < NSLOT; k++)
			vals[k] = '0;
		nlst = SLOT_W'(2);
		nerr = 1'b0;
		unique case (kind_s16)
			K_VERT: begin
				vals[0] = sat(cxp_s16);
				vals[1] = sat(cyp_s16);
				vals[2] = sat(czp_s16);
			end
			K_FACE: begin
				unique case (region_s16)
					R_YZ: begin
						vals[0] = v0;
						vals[1] = s_s16 ? v0 + row : v0 + lay;
						vals[2] = v0 + lay + row;
					end
					R_XZ: begin
						vals[0] = v0;
						vals[1] = s_s16 ? v0 + lay : v0 + one;
						vals[2] = v0 + lay + one;
					end
					default: begin
						vals[0] = s_s16 ? v0 + one : v0;
						vals[1] = s_s16 ? v0 + row : v0 + one;
						vals[2] = s_s16 ? v0 + row + one : v0 + row;
					end
				endcase
			end
			K_CELL: begin
				nlst     = SLOT_W'(NSLOT - 1);
				vals[0]  = f0;
				vals[2]  = f0 + VAL_W'(2);
				vals[4]  = f4;
				vals[6]  = f4 + (VAL_W'(w_q) << 1);
				vals[8]  = f8;
				vals[10] = f8 + (VAL_W'(wt_q) << 1);
				for (int k = 0; k < NSLOT; k += 2)
					vals[k+1] = vals[k] + one;
			end
			default: begin
				nlst = '0;
				nerr = 1'b1;
			end
		endcase
	end

	// output buffer: one result per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_busy_q <= 1'b0;
			ob_cnt_q  <= '0;
		end else if (en) begin
			ob_busy_q <= v_s16;
			ob_cnt_q  <= '0;
		end else if (take) begin
			ob_cnt_q <= ob_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ob_lst_q <= nlst;
			ob_err_q <= nerr;
			for (int k = 0; k < NSLOT; k++)
				ob_val_q[k] <= vals[k];
		end
	end

	assign m_tvalid = ob_busy_q;
	assign m_tdata  = {3'b000, ob_err_q, ob_val_q[ob_cnt_q], ob_cnt_q};
	assign m_tlast  = (ob_cnt_q == ob_lst_q);

endmodule

[dv/cuboid_grid_mesh_indexer_tb.sv]
// Self-checking testbench for the grid indexer: vertex, face and cell lookups.
// Predicts each answer from the register settings and compares every result.
// Depends on cgmi_pkg and cuboid_grid_mesh_indexer.
`timescale 1ns / 1ps

module cuboid_grid_mesh_indexer_tb;
	import cgmi_pkg::*;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  value;
		logic              error;
		logic              last;
	} answer_t;

	localparam int WATCHDOG = 20000;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [47:0]       m_tdata;
	logic              m_tlast;
	logic              cfg_we;
	logic [CFG_A_W-1:0] cfg_addr;
	logic [SP_W-1:0]   cfg_wdata;

	cuboid_grid_mesh_indexer dut (.*);

	// configuration copy
	logic [CNT_W-1:0] cnt_x, cnt_y, cnt_z;
	logic [SP_W-1:0]  sp_x, sp_y, sp_z;

	answer_t answers_due[$];
	int      fail_count;
	int      idle_cycles;
	int      hold_off;
	bit      done;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic longint unsigned eff(input logic [CNT_W-1:0] c);
		if (c == 0) return 1;
		if (c > MAX_CELLS) return MAX_CELLS;
		return c;
	endfunction

	function automatic longint unsigned scaled(input logic [SP_W-1:0] sp,
			input longint unsigned pos);
		longint unsigned p;
		p = longint'(sp) * pos;
		return (p > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : p;
	endfunction

	task automatic push_answer(input int slot, input longint unsigned v,
			input bit err, input bit lst);
		answer_t a;
		a.slot = SLOT_W'(slot);
		a.value = v[VAL_W-1:0];
		a.error = err;
		a.last = lst;
		answers_due.push_back(a);
	endtask

	// expected answer for one lookup
	task automatic predict_lookup(input logic [1:0] op, input logic [IDX_W-1:0] index);
		longint unsigned w, t, h, row, layer, nyz, nxz, nxy, idx;
		longint unsigned p, s, x, y, z, v0;
		longint unsigned v[3];
		longint unsigned f[12];
		w = eff(cnt_x);
		t = eff(cnt_y);
		h = eff(cnt_z);
		idx = index;
		row = w + 1;
		layer = (w + 1) * (t + 1);
		nyz = t * h * (w + 1);
		nxz = w * h * (t + 1);
		nxy = w * t * (h + 1);
		if (op == OP_VERTEX && idx < layer * (h + 1)) begin
			push_answer(0, scaled(sp_x, idx % row), 0, 0);
			push_answer(1, scaled(sp_y, (idx % layer) / row), 0, 0);
			push_answer(2, scaled(sp_z, idx / layer), 0, 1);
		end else if (op == OP_FACE && idx < 2 * (nyz + nxz + nxy)) begin
			p = idx >> 1;
			s = idx & 1;
			if (p < nyz) begin
				x = p % row; y = (p / row) % t; z = (p / row) / t;
				v0 = x + row * y + layer * z;
				v[0] = v0;
				if (s == 0) begin
					v[1] = v0 + layer; v[2] = v0 + layer + row;
				end else begin
					v[1] = v0 + row; v[2] = v0 + row + layer;
				end
			end else if (p - nyz < nxz) begin
				p -= nyz;
				x = p % w; y = (p / w) % (t + 1); z = (p / w) / (t + 1);
				v0 = x + row * y + layer * z;
				v[0] = v0;
				if (s == 0) begin
					v[1] = v0 + 1; v[2] = v0 + 1 + layer;
				end else begin
					v[1] = v0 + layer; v[2] = v0 + layer + 1;
				end
			end else begin
				p -= nyz + nxz;
				x = p % w; y = (p / w) % t; z = (p / w) / t;
				v0 = x + row * y + layer * z;
				if (s == 0) begin
					v[0] = v0; v[1] = v0 + 1; v[2] = v0 + row;
				end else begin
					v[0] = v0 + 1; v[1] = v0 + row; v[2] = v0 + row + 1;
				end
			end
			for (int k = 0; k < 3; k++)
				push_answer(k, v[k], 0, k == 2);
		end else if (op == OP_CELL && idx < w * t * h) begin
			x = idx % w; y = (idx / w) % t; z = (idx / w) / t;
			f[0] = 2 * (x + row * (y + z * t));
			f[2] = f[0] + 2;
			f[4] = 2 * (nyz + x + w * (y + z * (t + 1)));
			f[6] = f[4] + 2 * w;
			f[8] = 2 * (nyz + nxz + idx);
			f[10] = f[8] + 2 * w * t;
			for (int k = 0; k < 12; k += 2)
				f[k + 1] = f[k] + 1;
			for (int k = 0; k < 12; k++)
				push_answer(k, f[k], 0, k == 11);
		end else begin
			push_answer(0, 0, 1, 1);
		end
	endtask

	// element counts under the current setting
	function automatic longint unsigned kind_count(input logic [1:0] op);
		longint unsigned w, t, h;
		w = eff(cnt_x);
		t = eff(cnt_y);
		h = eff(cnt_z);
		case (op)
			OP_VERTEX: return (w + 1) * (t + 1) * (h + 1);
			OP_FACE: return 2 * (t * h * (w + 1) + w * h * (t + 1) + w * t * (h + 1));
			default: return w * t * h;
		endcase
	endfunction

	// valid stays up between back-to-back transactions; drain() drops it
	task automatic send_lookup(input logic [1:0] op, input logic [IDX_W-1:0] index);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, index};
		predict_lookup(op, index);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [SP_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= r;
		cfg_wdata <= v;
		case (r)
			REG_CX: cnt_x = v[CNT_W-1:0];
			REG_CY: cnt_y = v[CNT_W-1:0];
			REG_CZ: cnt_z = v[CNT_W-1:0];
			REG_SX: sp_x = v;
			REG_SY: sp_y = v;
			REG_SZ: sp_z = v;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_grid(input logic [SP_W-1:0] cx, input logic [SP_W-1:0] cy,
			input logic [SP_W-1:0] cz, input logic [SP_W-1:0] sx,
			input logic [SP_W-1:0] sy, input logic [SP_W-1:0] sz);
		drain();
		write_reg(REG_CX, cx);
		write_reg(REG_CY, cy);
		write_reg(REG_CZ, cz);
		write_reg(REG_SX, sx);
		write_reg(REG_SY, sy);
		write_reg(REG_SZ, sz);
		cfg_we <= 1'b0;
	endtask

	// random index mostly in range, sometimes at the edge or far beyond
	function automatic logic [IDX_W-1:0] pick_index(input logic [1:0] op);
		longint unsigned n;
		n = kind_count(op);
		case ($urandom_range(0, 9))
			0: return IDX_W'(n - 1);
			1: return IDX_W'(n);
			2: return IDX_W'($urandom());
			default: return IDX_W'($urandom_range(0, 32'(n - 1)));
		endcase
	endfunction

	task automatic test_reset_grid();
		send_lookup(OP_VERTEX, 0);
		send_lookup(OP_VERTEX, 7);
		send_lookup(OP_VERTEX, 8);
		send_lookup(OP_FACE, 0);
		send_lookup(OP_FACE, 35);
		send_lookup(OP_FACE, 36);
		send_lookup(OP_CELL, 0);
		send_lookup(OP_CELL, 1);
		send_lookup(2'd3, 0);
		send_lookup(OP_VERTEX, {IDX_W{1'b1}});
	endtask

	task automatic test_extremes();
		// zero counts act as one, spacing extremes
		set_grid(0, 0, 0, 32'hFFFF_FFFF, 0, 32'h5555_AAAA);
		send_lookup(OP_VERTEX, 7);
		send_lookup(OP_CELL, 0);
		set_grid(255, 255, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_lookup(OP_VERTEX, IDX_W'(kind_count(OP_VERTEX) - 1));
		send_lookup(OP_FACE, IDX_W'(kind_count(OP_FACE) - 1));
		send_lookup(OP_FACE, IDX_W'(kind_count(OP_FACE)));
		send_lookup(OP_CELL, IDX_W'(kind_count(OP_CELL) - 1));
		send_lookup(OP_CELL, IDX_W'(kind_count(OP_CELL)));
		send_lookup(2'd3, {IDX_W{1'b1}});
		send_lookup(OP_VERTEX, 27'h2AA_AAAA);
		send_lookup(OP_FACE, 27'h555_5555);
	endtask

	task automatic test_random(input int n);
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			if (i % 80 == 0)
				set_grid($urandom_range(0, 255), $urandom_range(0, 20),
					$urandom_range(0, 255), $urandom(), $urandom(), $urandom());
			op = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			send_lookup(op, pick_index(op));
		end
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		for (int i = 0; i < 30; i++)
			send_lookup(OP_CELL,
				IDX_W'($urandom_range(0, 32'(kind_count(OP_CELL) - 1))));
	endtask

	// result sink: random stalls plus a long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off) @(negedge clk);
				hold_off = 0;
			end
			stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				report($sformatf("unexpected result %h last %b", m_tdata, m_tlast));
			end else begin
				want = answers_due.pop_front();
				if (m_tdata[3:0] !== want.slot)
					report($sformatf("slot %0d, want %0d", m_tdata[3:0], want.slot));
				if (m_tdata[43:4] !== want.value)
					report($sformatf("value %h, want %h (slot %0d)", m_tdata[43:4],
						want.value, want.slot));
				if (m_tdata[44] !== want.error)
					report($sformatf("error %b, want %b", m_tdata[44], want.error));
				if (m_tlast !== want.last)
					report($sformatf("last %b, want %b", m_tlast, want.last));
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if (!done) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		hold_off = 0;
		done = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		cnt_x = 1; cnt_y = 1; cnt_z = 1;
		sp_x = 65536; sp_y = 65536; sp_z = 65536;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_grid();
		test_extremes();
		test_random(440);
		test_backpressure();
		drain();
		done = 1'b1;
		if (fail_count == 0 && answers_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
